### hdl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types and constants shared by the RTCM3 frame delimiter modules.
// ----------------------------------------------------------------------------
package rfd_pkg;

	// frame layout
	localparam int unsigned HEADER_BYTES = 3;
	localparam int unsigned CRC_BYTES    = 3;

	localparam int unsigned CNT_W = 11;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned ID_W  = 12;

	// positions of the message id bytes and first position with a full id
	localparam logic [CNT_W-1:0] ID_HI_POS    = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] ID_LO_POS    = CNT_W'(HEADER_BYTES + 1);
	localparam logic [CNT_W-1:0] ID_FULL_CNT  = CNT_W'(HEADER_BYTES + 2);
	localparam logic [CNT_W-1:0] LEN_HI_POS   = CNT_W'(1);
	localparam logic [CNT_W-1:0] HDR_CNT      = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] FRAME_EXTRA  = CNT_W'(HEADER_BYTES + CRC_BYTES);

	// configuration register reset values
	localparam logic [7:0]       PREAMBLE_RESET = 8'hD3;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET  = '1;

	// apb address width and register indexes
	localparam int unsigned ADDR_W = 3;
	typedef enum logic {
		REG_PREAMBLE = 1'b0,
		REG_MAX_LEN  = 1'b1
	} reg_idx_t;

	// input word operation codes
	typedef enum logic {
		OP_DATA    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	// parser phase
	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_HEADER = 2'd1,
		PH_BODY   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       phase;
		logic             byte_stored;
		logic [CNT_W-1:0] byte_position;
		logic [CNT_W-1:0] received_count;
		logic [LEN_W-1:0] body_length;
		logic [ID_W-1:0]  message_number;
		logic             id_valid;
		logic             length_rejected;
	} res_t;

	// register values handed from the config block to the parser
	typedef struct packed {
		logic [7:0]       preamble;
		logic [LEN_W-1:0] max_len;
	} cfg_t;

endpackage

### hdl/rfd_cfg.sv
// ----------------------------------------------------------------------------
// rfd_cfg
// APB register file holding the preamble value and the maximum body length.
// ----------------------------------------------------------------------------
module rfd_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output rfd_pkg::cfg_t             cfg
);
	import rfd_pkg::*;

	logic [7:0]       preamble_q;
	logic [LEN_W-1:0] max_len_q;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
			max_len_q  <= MAX_LEN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_PREAMBLE: preamble_q <= pwdata[7:0];
				REG_MAX_LEN:  max_len_q  <= pwdata[LEN_W-1:0];
				default:      ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_PREAMBLE: prdata = {24'd0, preamble_q};
			REG_MAX_LEN:  prdata = {{(32-LEN_W){1'b0}}, max_len_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.preamble = preamble_q;
	assign cfg.max_len  = max_len_q;

endmodule

### hdl/rfd_parser.sv
// ----------------------------------------------------------------------------
// rfd_parser
// Frame phase tracking and byte results, one word per cycle while accepting.
// ----------------------------------------------------------------------------
module rfd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  rfd_pkg::cfg_t cfg,
	input  logic          accept,
	input  rfd_pkg::cmd_t cmd,
	output rfd_pkg::res_t res
);
	import rfd_pkg::*;

	phase_t           phase_q, phase_n;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_inc;
	logic [LEN_W-1:0] len_q, len_n, hdr_len;
	logic [1:0]       lhb_q, lhb_n;
	logic [ID_W-1:0]  id_q, id_n;
	logic [CNT_W-1:0] total_hdr, total_q;
	logic             is_pre, hdr_end, too_long;
	logic             stored, rejected;
	logic [CNT_W-1:0] pos;
	logic             idv;

	// shared datapath terms
	// length high bits were captured on an earlier header byte
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign is_pre    = (cmd.data_byte == cfg.preamble);
	assign hdr_end   = (cnt_inc >= HDR_CNT);
	assign hdr_len   = {lhb_q, cmd.data_byte};
	assign too_long  = hdr_len > cfg.max_len;
	assign total_hdr = CNT_W'(hdr_len) + FRAME_EXTRA;
	assign total_q   = CNT_W'(len_q) + FRAME_EXTRA;

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (cmd.operation == OP_RESTART) begin
			phase_n = PH_SEARCH;
		end else begin
			unique case (phase_q)
				PH_SEARCH: if (is_pre) phase_n = PH_HEADER;
				PH_HEADER: begin
					if (hdr_end) begin
						if (too_long)                 phase_n = PH_SEARCH;
						else if (cnt_inc >= total_hdr) phase_n = PH_DONE;
						else                          phase_n = PH_BODY;
					end
				end
				PH_BODY:   if (cnt_inc >= total_q) phase_n = PH_DONE;
				PH_DONE:   ;
				default:   ;
			endcase
		end
	end

	// counters, captured fields and per-byte flags
	always_comb begin
		cnt_n    = cnt_q;
		len_n    = len_q;
		lhb_n    = lhb_q;
		id_n     = id_q;
		stored   = 1'b0;
		pos      = '0;
		rejected = 1'b0;
		if (cmd.operation == OP_RESTART) begin
			cnt_n = '0;
			len_n = '0;
			lhb_n = '0;
			id_n  = '0;
		end else begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (is_pre) begin
						stored = 1'b1;
						pos    = cnt_q;
						cnt_n  = CNT_W'(1);
					end
				end
				PH_HEADER: begin
					stored = 1'b1;
					pos    = cnt_q;
					cnt_n  = cnt_inc;
					if (cnt_q == LEN_HI_POS) lhb_n = cmd.data_byte[1:0];
					if (hdr_end) begin
						len_n = hdr_len;
						if (too_long) begin
							cnt_n    = '0;
							len_n    = '0;
							lhb_n    = '0;
							id_n     = '0;
							stored   = 1'b0;
							pos      = '0;
							rejected = 1'b1;
						end
					end
				end
				PH_BODY: begin
					stored = 1'b1;
					pos    = cnt_q;
					cnt_n  = cnt_inc;
					if (cnt_q == ID_HI_POS)
						id_n = {cmd.data_byte, 4'd0};
					else if (cnt_q == ID_LO_POS)
						id_n = {id_q[ID_W-1:4], cmd.data_byte[7:4]};
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	assign idv = (cnt_n >= ID_FULL_CNT);

	// result word for this byte
	always_comb begin
		res.phase           = phase_n;
		res.byte_stored     = stored;
		res.byte_position   = pos;
		res.received_count  = cnt_n;
		res.body_length     = len_n;
		res.message_number  = idv ? id_n : '0;
		res.id_valid        = idv;
		res.length_rejected = rejected;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			cnt_q   <= '0;
			len_q   <= '0;
			lhb_q   <= '0;
			id_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			lhb_q   <= lhb_n;
			id_q    <= id_n;
		end
	end

endmodule

### hdl/rfd_out_buf.sv
// ----------------------------------------------------------------------------
// rfd_out_buf
// Result register with a skid entry so the input side can deliver one more
// result while the output is stalled.
// ----------------------------------------------------------------------------
module rfd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rfd_pkg::res_t din,
	output logic          full,
	output logic          res_valid,
	input  logic          res_stall,
	output rfd_pkg::res_t res
);
	import rfd_pkg::*;

	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic out_busy;

	assign out_busy  = out_vld_q & res_stall;
	assign full      = skid_vld_q;
	assign res_valid = out_vld_q;
	assign res       = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			if (out_busy) skid_vld_q <= 1'b1;
			else          out_vld_q  <= 1'b1;
		end else if (!out_busy) begin
			out_vld_q  <= skid_vld_q;
			skid_vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			if (out_busy) skid_q <= din;
			else          out_q  <= din;
		end else if (!out_busy && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

endmodule

### hdl/rtcm3_frame_delimiter_top.sv
// One byte word is taken per clock cycle while cmd_stall is low, as the
// parser update is a single compare and counter step. Its result word is
// registered in the output register, or in the skid entry while the output
// is stalled. The skid lets the input keep going during an output stall;
// cmd_stall rises only once both result entries are held. A restart word
// returns the parser to searching but keeps the configuration registers.
// ----------------------------------------------------------------------------
// rtcm3_frame_delimiter_top
// RTCM3 frame delimiter: finds the preamble, parses the body length and
// message id, and reports the frame position of every stored byte.
// ----------------------------------------------------------------------------
module rtcm3_frame_delimiter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  rfd_pkg::cmd_t              cmd,
	output logic                       res_valid,
	input  logic                       res_stall,
	output rfd_pkg::res_t              res
);
	import rfd_pkg::*;

	cfg_t cfg;
	res_t step_res;
	logic full;
	logic accept;

	assign cmd_stall = full;
	assign accept    = cmd_valid & ~full;

	// configuration registers
	rfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// frame parser
	rfd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.cmd    (cmd),
		.res    (step_res)
	);

	// result register and skid
	rfd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (step_res),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

### tb/rtcm3_frame_delimiter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcm3_frame_delimiter_top_test
// Self-checking bench for the RTCM3 frame delimiter. Byte and restart words
// go in over the valid/stall port, and an internal parser model tracks the
// frame phase, byte counter, body length and message id. Every result word
// is compared field by field with the model. The configuration registers
// are rewritten over the APB port between phases. Both sides idle and stall
// at random, and one phase holds the result side for a long stretch.
// ----------------------------------------------------------------------------
module rtcm3_frame_delimiter_top_test;
	import rfd_pkg::*;

	localparam int HDR_LEN     = 3;
	localparam int CRC_LEN     = 3;
	localparam int ID_DONE     = HDR_LEN + 2;
	localparam int LONG_HOLD   = 64;
	localparam int CYCLE_LIMIT = 400000;

	// frame parser model and the queue of result words it predicts
	class frame_tracker;
		logic [7:0]       preamble = 8'hD3;
		logic [LEN_W-1:0] max_len  = 10'h3FF;
		phase_t           ph       = PH_SEARCH;
		logic [CNT_W-1:0] count    = '0;
		logic [LEN_W-1:0] blen     = '0;
		logic [1:0]       len_top  = '0;
		logic [ID_W-1:0]  msg_id   = '0;
		res_t             expected_reports[$];
		int               words_checked = 0;
		int               errors = 0;

		function void restart_parser();
			ph      = PH_SEARCH;
			count   = '0;
			blen    = '0;
			len_top = '0;
			msg_id  = '0;
		endfunction

		function res_t parse_word(cmd_t w);
			res_t             r;
			logic [CNT_W-1:0] pos;
			logic [CNT_W-1:0] frame_len;
			logic             stored;
			logic             rejected;
			stored   = 1'b0;
			pos      = '0;
			rejected = 1'b0;
			if (w.operation == OP_RESTART) begin
				restart_parser();
			end else begin
				case (ph)
					PH_SEARCH: begin
						if (w.data_byte == preamble) begin
							stored = 1'b1;
							pos    = count;
							count  = CNT_W'(1);
							ph     = PH_HEADER;
						end
					end
					PH_HEADER: begin
						stored = 1'b1;
						pos    = count;
						count  = count + CNT_W'(1);
						if (pos == CNT_W'(1))
							len_top = w.data_byte[1:0];
						// last header byte: length known, check it against the limit
						if (count >= CNT_W'(HDR_LEN)) begin
							blen = {len_top, w.data_byte};
							if (blen > max_len) begin
								restart_parser();
								stored   = 1'b0;
								pos      = '0;
								rejected = 1'b1;
							end else begin
								frame_len = CNT_W'(blen) + CNT_W'(HDR_LEN + CRC_LEN);
								ph = (count >= frame_len) ? PH_DONE : PH_BODY;
							end
						end
					end
					PH_BODY: begin
						stored = 1'b1;
						pos    = count;
						count  = count + CNT_W'(1);
						// message id: all of the first body byte, high nibble of the next
						if (pos == CNT_W'(HDR_LEN))
							msg_id = {w.data_byte, 4'h0};
						else if (pos == CNT_W'(HDR_LEN + 1))
							msg_id = {msg_id[11:4], w.data_byte[7:4]};
						frame_len = CNT_W'(blen) + CNT_W'(HDR_LEN + CRC_LEN);
						if (count >= frame_len)
							ph = PH_DONE;
					end
					default: ;
				endcase
			end
			r.phase           = ph;
			r.byte_stored     = stored;
			r.byte_position   = pos;
			r.received_count  = count;
			r.body_length     = blen;
			r.id_valid        = (count >= CNT_W'(ID_DONE));
			r.message_number  = r.id_valid ? msg_id : '0;
			r.length_rejected = rejected;
			return r;
		endfunction

		function void note_word(cmd_t w);
			expected_reports.push_back(parse_word(w));
		endfunction

		task report_mismatch(string msg);
			if (errors < 30)
				$display("[%0t] word %0d: %s", $realtime, words_checked, msg);
			errors++;
		endtask

		task check_report(res_t got);
			res_t exp;
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
				return;
			end
			exp = expected_reports.pop_front();
			if (got.phase !== exp.phase)
				report_mismatch($sformatf("phase %0d, want %0d", got.phase, exp.phase));
			if (got.byte_stored !== exp.byte_stored)
				report_mismatch($sformatf("byte_stored %b, want %b",
					got.byte_stored, exp.byte_stored));
			if (got.byte_position !== exp.byte_position)
				report_mismatch($sformatf("byte_position %0d, want %0d",
					got.byte_position, exp.byte_position));
			if (got.received_count !== exp.received_count)
				report_mismatch($sformatf("received_count %0d, want %0d",
					got.received_count, exp.received_count));
			if (got.body_length !== exp.body_length)
				report_mismatch($sformatf("body_length %0d, want %0d",
					got.body_length, exp.body_length));
			if (got.message_number !== exp.message_number)
				report_mismatch($sformatf("message_number %h, want %h",
					got.message_number, exp.message_number));
			if (got.id_valid !== exp.id_valid)
				report_mismatch($sformatf("id_valid %b, want %b", got.id_valid, exp.id_valid));
			if (got.length_rejected !== exp.length_rejected)
				report_mismatch($sformatf("length_rejected %b, want %b",
					got.length_rejected, exp.length_rejected));
			words_checked++;
		endtask
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [31:0]       pwdata    = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	cmd_t              cmd       = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_t              res;

	frame_tracker tracker = new;

	int        cycles      = 0;
	int        words_sent  = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        hold_req    = 0;
	int        hold_seen   = 0;
	int        stall_left  = 0;
	logic [7:0] cfg_preamble = 8'hD3;
	int        cfg_max_len  = 1023;

	rtcm3_frame_delimiter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// note accepted words, then check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				tracker.note_word(cmd);
			if (res_valid && !res_stall)
				tracker.check_report(res);
		end
	end

	// result side stall: one long hold on request, else short random bursts
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen  <= hold_req;
			stall_left <= LONG_HOLD;
			res_stall  <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_stall  <= 1'b1;
		end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
			stall_left <= $urandom_range(0, 2);
			res_stall  <= 1'b1;
		end else
			res_stall <= 1'b0;
	end

	task automatic set_idling(int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
	endtask

	// offer one word, with an optional gap before it, and wait until taken
	task automatic send_word(op_t op, logic [7:0] value);
		cmd_t w;
		w.operation = op;
		w.data_byte = value;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_restart();
		send_word(OP_RESTART, 8'($urandom));
	endtask

	// preamble, two header bytes carrying len, then body_sent body/crc bytes
	task automatic send_frame(int len, int body_sent);
		logic [9:0] l;
		l = 10'(len);
		send_word(OP_DATA, cfg_preamble);
		send_word(OP_DATA, {6'($urandom), l[9:8]});
		send_word(OP_DATA, l[7:0]);
		repeat (body_sent) send_word(OP_DATA, 8'($urandom));
	endtask

	task automatic pause_until_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// reprogram both registers once the parser has gone quiet
	task automatic configure(logic [7:0] pre, logic [9:0] max_len);
		pause_until_drained();
		reg_write(REG_PREAMBLE, {24'h0, pre});
		reg_write(REG_MAX_LEN, {22'h0, max_len});
		tracker.preamble = pre;
		tracker.max_len  = max_len;
		cfg_preamble     = pre;
		cfg_max_len      = int'(max_len);
	endtask

	task automatic run_directed();
		// reset values: noise, a zero-length frame, bytes after completion
		send_restart();
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'hFF);
		send_word(OP_DATA, 8'hD3);
		send_word(OP_DATA, 8'hFC);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'hFF);
		send_word(OP_DATA, 8'h0F);
		send_word(OP_DATA, 8'hAA);
		send_word(OP_DATA, 8'hD3);
		send_restart();
		// longest body accepted, then restart in the middle of the body
		send_word(OP_DATA, 8'hD3);
		send_word(OP_DATA, 8'h03);
		send_word(OP_DATA, 8'hFF);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'hF0);
		send_restart();
		// zero limit: oversized headers are dropped, empty body still fits
		configure(8'h00, 10'd0);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'h01);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'hFF);
		send_word(OP_DATA, 8'hFF);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'h00);
		send_restart();
	endtask

	// one mostly well-formed frame with random content, sometimes broken
	task automatic random_sequence();
		int         kind;
		int         len;
		int         cut;
		int         top;
		logic [7:0] b;
		if ($urandom_range(0, 9) != 0)
			send_restart();
		// noise ahead of the preamble
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom);
				if (b == cfg_preamble)
					b = ~b;
				send_word(OP_DATA, b);
			end
		end
		kind = $urandom_range(0, 9);
		top  = (cfg_max_len < 24) ? cfg_max_len : 24;
		if (kind == 8 && cfg_max_len < 1023) begin
			len = $urandom_range(cfg_max_len + 1, 1023);
			cut = $urandom_range(0, 3);
		end else begin
			if (kind == 7)
				len = (cfg_max_len < 40) ? cfg_max_len : $urandom_range(0, 40);
			else
				len = $urandom_range(0, top);
			cut = len + CRC_LEN;
			if (kind == 9)
				cut = $urandom_range(0, cut);
		end
		send_frame(len, cut);
		// bytes past the frame end are discarded
		repeat ($urandom_range(0, 3)) send_word(OP_DATA, 8'($urandom));
	endtask

	task automatic run_random(int budget, bit vary_idle);
		int start;
		start = words_sent;
		while (words_sent - start < budget) begin
			if (vary_idle && $urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 2))
					0: set_idling(0, 0);
					1: set_idling(10, 10);
					default: set_idling(35, 35);
				endcase
			end
			random_sequence();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();

		// reset values again, with one frame of the longest body
		set_idling(20, 20);
		configure(8'hD3, 10'd1023);
		send_restart();
		send_frame(1023, 1023 + CRC_LEN);
		run_random(70, 1'b1);

		// zero preamble and zero limit, result side held off for a while
		configure(8'h00, 10'd0);
		set_idling(30, 10);
		hold_req <= hold_req + 1;
		run_random(110, 1'b0);

		// all-ones preamble, short limit, sender waits for the results midway
		configure(8'hFF, 10'd7);
		set_idling(15, 25);
		run_random(55, 1'b1);
		pause_until_drained();
		run_random(55, 1'b1);

		configure(8'($urandom), 10'($urandom_range(0, 40)));
		run_random(110, 1'b1);

		// closing stretch runs at full rate
		configure(8'hD3, 10'd12);
		set_idling(0, 0);
		run_random(110, 1'b0);

		pause_until_drained();
		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
